>>> hdl/zcs_pkg.sv
// Shared constants and types for the zero crossing snap block.
`default_nettype none

package zcs_pkg;

  localparam int ADDR_BITS_DEF     = 16;
  localparam int SEARCH_RADIUS_DEF = 1024;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int ADDRESS_W = 16;
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 17;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_FIRST,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

>>> hdl/zcs_mem.sv
// Sample memory: one write port, one read port with registered read data.
`default_nettype none

module zcs_mem #(
  parameter int ADDR_BITS   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [ADDR_BITS-1:0]   wr_addr,
  input  wire logic [SAMPLE_BITS-1:0] wr_data,
  input  wire logic [ADDR_BITS-1:0]   rd_addr,
  output logic      [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/zcs_ctrl.sv
// Sequencer: takes items, scans the sample memory and holds the result register.
`default_nettype none

module zcs_ctrl #(
  parameter int ADDR_BITS     = 16,
  parameter int SAMPLE_BITS   = 16,
  parameter int SEARCH_RADIUS = 1024,
  parameter int CNT_BITS      = 17
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [CNT_BITS-1:0]    count,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire zcs_pkg::kind_t         in_kind,
  input  wire logic [ADDR_BITS-1:0]   in_addr,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [ADDR_BITS-1:0]   out_pos,
  output logic                        out_flag,
  output logic                        mem_wr_en,
  output logic      [ADDR_BITS-1:0]   mem_wr_addr,
  output logic      [SAMPLE_BITS-1:0] mem_wr_data,
  output logic      [ADDR_BITS-1:0]   mem_rd_addr,
  input  wire logic [SAMPLE_BITS-1:0] mem_rd_data
);

  import zcs_pkg::*;

  state_t                 state, state_next;
  logic [ADDR_BITS-1:0]   qaddr, qaddr_next;
  logic                   oor, oor_next;
  logic [ADDR_BITS-1:0]   best, best_next;
  logic [ADDR_BITS-1:0]   best_dist, best_dist_next;
  logic [SAMPLE_BITS-1:0] best_mag, best_mag_next;
  logic [CNT_BITS-1:0]    cur, cur_next;
  logic [CNT_BITS-1:0]    last, last_next;
  logic [SAMPLE_BITS-1:0] prev, prev_next;
  logic                   out_valid_next;
  logic [ADDR_BITS-1:0]   out_pos_next;
  logic                   out_flag_next;

  logic [CNT_BITS-1:0]    radius;
  logic [CNT_BITS-1:0]    qext;
  logic [CNT_BITS-1:0]    first_ix;
  logic [CNT_BITS-1:0]    hi_ix;
  logic [CNT_BITS-1:0]    cmax;
  logic [CNT_BITS-1:0]    end_ix;
  logic [CNT_BITS-1:0]    cur_inc;
  logic [CNT_BITS-1:0]    in_ext;
  logic [SAMPLE_BITS-1:0] rd_mag;
  logic [ADDR_BITS-1:0]   cur_dist;
  logic                   crossing;
  logic                   accept;
  logic                   out_free;

  assign radius   = CNT_BITS'(SEARCH_RADIUS);
  assign qext     = CNT_BITS'(qaddr);
  assign in_ext   = CNT_BITS'(in_addr);
  assign first_ix = (qext > radius) ? (qext - radius - CNT_BITS'(1)) : '0;
  assign hi_ix    = qext + radius;
  assign cmax     = count - CNT_BITS'(1);
  assign end_ix   = (hi_ix > cmax) ? cmax : hi_ix;
  assign cur_inc  = cur + CNT_BITS'(1);
  assign rd_mag   = mem_rd_data[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - mem_rd_data) : mem_rd_data;
  assign cur_dist = (cur >= qext) ? ADDR_BITS'(cur - qext) : ADDR_BITS'(qext - cur);
  assign crossing = (prev == '0) || (mem_rd_data == '0)
                    || (prev[SAMPLE_BITS-1] != mem_rd_data[SAMPLE_BITS-1]);
  assign out_free = !out_valid || out_ready;

  assign in_ready    = (state == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign mem_wr_en   = accept && (in_kind == KIND_WRITE);
  assign mem_wr_addr = in_addr;
  assign mem_wr_data = in_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    qaddr     <= qaddr_next;
    oor       <= oor_next;
    best      <= best_next;
    best_dist <= best_dist_next;
    best_mag  <= best_mag_next;
    cur       <= cur_next;
    last      <= last_next;
    prev      <= prev_next;
    out_pos   <= out_pos_next;
    out_flag  <= out_flag_next;
  end

  always_comb begin
    state_next     = state;
    qaddr_next     = qaddr;
    oor_next       = oor;
    best_next      = best;
    best_dist_next = best_dist;
    best_mag_next  = best_mag;
    cur_next       = cur;
    last_next      = last;
    prev_next      = prev;
    out_valid_next = out_valid && !out_ready;
    out_pos_next   = out_pos;
    out_flag_next  = out_flag;
    mem_rd_addr    = in_addr;

    case (state)
      ST_IDLE: begin
        mem_rd_addr = in_addr;
        if (accept && (in_kind == KIND_QUERY)) begin
          qaddr_next     = in_addr;
          best_next      = in_addr;
          best_dist_next = '0;
          oor_next       = (in_ext >= count);
          state_next     = (in_ext >= count) ? ST_FIN : ST_MAG;
        end
      end
      ST_MAG: begin
        mem_rd_addr   = first_ix[ADDR_BITS-1:0];
        best_mag_next = rd_mag;
        cur_next      = first_ix;
        last_next     = end_ix;
        state_next    = ST_FIRST;
      end
      ST_FIRST: begin
        mem_rd_addr = cur_inc[ADDR_BITS-1:0];
        prev_next   = mem_rd_data;
        if (cur_inc < last) begin
          cur_next   = cur_inc;
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SCAN: begin
        mem_rd_addr = cur_inc[ADDR_BITS-1:0];
        prev_next   = mem_rd_data;
        if (crossing && ((cur_dist < best_dist) || (rd_mag < best_mag))) begin
          best_next      = cur[ADDR_BITS-1:0];
          best_dist_next = cur_dist;
          best_mag_next  = rd_mag;
        end
        if (cur_inc < last) begin
          cur_next = cur_inc;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_pos_next   = best;
          out_flag_next  = oor;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/zero_crossing_snap.sv
// Top level of the zero crossing snap block: ports, count register, memory, sequencer.
//
//   channel   | signals                          | carries
//   s_axis    | tvalid tready tdata tuser        | sample writes and snap queries
//   m_axis    | tvalid tready tdata tuser        | snapped positions
//   cfg       | valid ready data                 | sample count
//
// A write leaves the sequencer in IDLE. An out-of-range query goes from IDLE straight
// to FIN, which loads the result register. An in-range query reads the sample at its
// position, then one sample per cycle over its window through the single memory read
// port. Reset clears the sequencer, the result valid flag and the count; the sample
// memory is not cleared. A stalled result holds in the output register while new items
// are taken; a finished query then waits until the register frees.
`default_nettype none

module zero_crossing_snap #(
  parameter int ADDR_BITS     = zcs_pkg::ADDR_BITS_DEF,
  parameter int SEARCH_RADIUS = zcs_pkg::SEARCH_RADIUS_DEF,
  parameter int SAMPLE_BITS   = zcs_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          s_axis_tvalid,
  output logic                                               s_axis_tready,
  // address [15:0], sample_value [31:16]
  input  wire logic [zcs_pkg::ADDRESS_W+zcs_pkg::SAMPLE_W-1:0] s_axis_tdata,
  // kind [0]
  input  wire logic [0:0]                                    s_axis_tuser,
  output logic                                               m_axis_tvalid,
  input  wire logic                                          m_axis_tready,
  // snapped_position [15:0]
  output logic      [zcs_pkg::ADDRESS_W-1:0]                 m_axis_tdata,
  // out_of_range [0]
  output logic      [0:0]                                    m_axis_tuser,
  input  wire logic                                          cfg_valid,
  output logic                                               cfg_ready,
  input  wire logic [zcs_pkg::COUNT_W-1:0]                   cfg_data
);

  import zcs_pkg::*;

  localparam int CNT_BITS = (ADDR_BITS + 1 > COUNT_W) ? ADDR_BITS + 1 : COUNT_W;
  localparam logic [CNT_BITS-1:0] DEPTH = CNT_BITS'(1) << ADDR_BITS;

  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    count_next;
  logic [CNT_BITS-1:0]    cfg_ext;
  logic [ADDR_BITS-1:0]   out_pos;
  logic                   out_flag;
  logic                   mem_wr_en;
  logic [ADDR_BITS-1:0]   mem_wr_addr;
  logic [SAMPLE_BITS-1:0] mem_wr_data;
  logic [ADDR_BITS-1:0]   mem_rd_addr;
  logic [SAMPLE_BITS-1:0] mem_rd_data;

  assign cfg_ready  = 1'b1;
  assign cfg_ext    = CNT_BITS'(cfg_data);
  assign count_next = (cfg_ext > DEPTH) ? DEPTH : cfg_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count <= count_next;
    end
  end

  zcs_mem #(
    .ADDR_BITS   (ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  zcs_ctrl #(
    .ADDR_BITS     (ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .SEARCH_RADIUS (SEARCH_RADIUS),
    .CNT_BITS      (CNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .count       (count),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_kind     (kind_t'(s_axis_tuser[0])),
    .in_addr     (ADDR_BITS'(s_axis_tdata[ADDRESS_W-1:0])),
    .in_sample   (SAMPLE_BITS'(s_axis_tdata[ADDRESS_W+SAMPLE_W-1:ADDRESS_W])),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_pos     (out_pos),
    .out_flag    (out_flag),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  assign m_axis_tdata    = ADDRESS_W'(out_pos);
  assign m_axis_tuser[0] = out_flag;

  a_query_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == KIND_QUERY) |=> !s_axis_tready)
    else $error("intake open right after a query transaction");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == KIND_WRITE) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("write transaction produced a result");

  a_in_range_below_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> (CNT_BITS'(out_pos) < count))
    else $error("in-range result at or beyond the sample count");

endmodule

`default_nettype wire
